FILE: hdl/citt_pkg.sv
// shared types and constants of the clock input tempo tracker
`default_nettype none

package citt_pkg;

   typedef enum logic [3:0] {
      METHOD_PCT    = 4'd0,
      METHOD_FLAT5  = 4'd1,
      METHOD_FLAT10 = 4'd2,
      METHOD_MAVG4  = 4'd3,
      METHOD_BLK8   = 4'd4,
      METHOD_BLK4   = 4'd5,
      METHOD_MAVG2  = 4'd6,
      METHOD_EXP4   = 4'd7,
      METHOD_EXP8   = 4'd8,
      METHOD_DIRECT = 4'd9
   } method_type;

   typedef enum logic [1:0] {
      REG_METHOD = 2'd0,
      REG_LOCK_A = 2'd1,
      REG_LOCK_B = 2'd2
   } reg_index_type;

   localparam int unsigned RING_DEPTH = 8;
   localparam int unsigned RING_IDX_W = 3;

   localparam logic [38:0] PCT_SCALE = 39'd100;
   localparam logic [38:0] PCT_HIGH  = 39'd101;
   localparam logic [38:0] PCT_LOW   = 39'd99;

   localparam logic [31:0] FLAT5_LIMIT  = 32'd5;
   localparam logic [31:0] FLAT10_LIMIT = 32'd10;

   localparam logic [3:0] MAVG4_LEN = 4'd4;
   localparam logic [3:0] BLK4_LEN  = 4'd4;
   localparam logic [3:0] BLK8_LEN  = 4'd8;

   localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

FILE: hdl/clock_input_tempo_tracker.sv
// clock input tempo tracker: edge qualification, period capture and smoothing
//
// Input transfers on req_: tuser carries the item kind (0 jack sample, 1 elapsed
// tick), tdata[0] carries the jack level of a sample item. Every accepted item
// gives exactly one result transfer on rsp_ with the edge, pulse and channel
// change flags and the tracked period after that item.
// A qualified edge is a run of LOW_RUN low samples followed by one high sample;
// it captures the elapsed tick count, clears it and updates the period by the
// method selected in the csr_ register file (0x0 method, 0x4 lock A, 0x8 lock B).
// Throughput is one item per cycle while the output is not stalled: all state is
// updated in the cycle of the input transfer, through one pass of logic that holds
// the pct products, the ring adder tree and the exponential sums. The result sits
// in the output register the cycle after acceptance.
// While rsp_tready is low the result is held and req_tready drops only once the
// output register is full; an item is accepted in the cycle the previous result leaves.
// Reset clears history, counters, period, ring and flags, selects direct
// tracking and unlocks both channels.
`default_nettype none

module clock_input_tempo_tracker #(
   parameter int unsigned LOW_RUN = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // jack_level, zero fill
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // edge_seen, clock_pulse, changed_a, changed_b,
                                         // period_out, zero fill
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned HIST_W = LOW_RUN + 1;
   localparam logic [HIST_W-1:0] EDGE_PATTERN = {{LOW_RUN{1'b1}}, 1'b0};

   logic [3:0]  method_ff;
   logic        lock_a_ff;
   logic        lock_b_ff;

   logic [HIST_W-1:0] hist_ff, hist_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] period_ff, period_in;
   logic [31:0] ring_ff [citt_pkg::RING_DEPTH];
   logic [31:0] ring_in [citt_pkg::RING_DEPTH];
   logic [31:0] ring_wr [citt_pkg::RING_DEPTH];
   logic [citt_pkg::RING_IDX_W-1:0] idx_ff, idx_in;
   logic        full_ff, full_in;
   logic [31:0] prev_ff, prev_in;

   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   logic        req_accept;
   logic        csr_write;
   logic        edge_hit;
   logic        changed;
   logic        pulse;
   logic        chg_a;
   logic        chg_b;

   logic [31:0] capture;
   logic [38:0] cap_scaled;
   logic [38:0] per_high;
   logic [38:0] per_low;
   logic [31:0] diff;
   logic [3:0]  idx_inc;
   logic [33:0] sum4;
   logic [34:0] sum8;
   logic [32:0] mavg2_sum;
   logic [34:0] exp4_sum;
   logic [34:0] exp8_sum;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // datapath for the capture
   assign capture    = elapsed_ff;
   assign cap_scaled = {7'd0, capture} * citt_pkg::PCT_SCALE;
   assign per_high   = {7'd0, period_ff} * citt_pkg::PCT_HIGH;
   assign per_low    = {7'd0, period_ff} * citt_pkg::PCT_LOW;
   assign diff       = (capture > period_ff) ? capture - period_ff : period_ff - capture;
   assign idx_inc    = {1'b0, idx_ff} + 4'd1;
   assign mavg2_sum  = {1'b0, capture} + {1'b0, prev_ff};
   assign exp4_sum   = {3'd0, capture} + {2'd0, period_ff, 1'b0} + {3'd0, period_ff};
   assign exp8_sum   = {3'd0, capture} + {period_ff, 3'd0} - {3'd0, period_ff};

   always_comb begin
      for (int i = 0; i < citt_pkg::RING_DEPTH; i++) begin
         ring_wr[i] = (idx_ff == i[citt_pkg::RING_IDX_W-1:0]) ? capture : ring_ff[i];
      end
   end

   assign sum4 = {2'd0, ring_wr[0]} + {2'd0, ring_wr[1]}
               + {2'd0, ring_wr[2]} + {2'd0, ring_wr[3]};
   assign sum8 = {1'b0, sum4} + {3'd0, ring_wr[4]} + {3'd0, ring_wr[5]}
               + {3'd0, ring_wr[6]} + {3'd0, ring_wr[7]};

   always_comb begin
      hist_in    = hist_ff;
      elapsed_in = elapsed_ff;
      period_in  = period_ff;
      ring_in    = ring_ff;
      idx_in     = idx_ff;
      full_in    = full_ff;
      prev_in    = prev_ff;
      edge_hit   = 1'b0;
      changed    = 1'b0;
      if (req_accept) begin
         if (req_tuser) begin
            if (elapsed_ff != citt_pkg::ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 32'd1;
            end
         end else begin
            hist_in = {hist_ff[HIST_W-2:0], ~req_tdata[0]};
            if (hist_in == EDGE_PATTERN) begin
               edge_hit   = 1'b1;
               elapsed_in = '0;
               changed    = 1'b1;
               if (method_ff != citt_pkg::METHOD_MAVG4 && method_ff != citt_pkg::METHOD_BLK8
                   && method_ff != citt_pkg::METHOD_BLK4) begin
                  idx_in  = '0;
                  full_in = 1'b0;
               end
               case (method_ff)
                  citt_pkg::METHOD_PCT: begin
                     if (cap_scaled > per_high || cap_scaled < per_low) begin
                        period_in = capture;
                     end else begin
                        changed = 1'b0;
                     end
                  end
                  citt_pkg::METHOD_FLAT5: begin
                     if (diff > citt_pkg::FLAT5_LIMIT) begin
                        period_in = capture;
                     end else begin
                        changed = 1'b0;
                     end
                  end
                  citt_pkg::METHOD_FLAT10: begin
                     if (diff > citt_pkg::FLAT10_LIMIT) begin
                        period_in = capture;
                     end else begin
                        changed = 1'b0;
                     end
                  end
                  citt_pkg::METHOD_MAVG4: begin
                     ring_in   = ring_wr;
                     period_in = full_ff ? sum4[33:2] : capture;
                     if (idx_inc >= citt_pkg::MAVG4_LEN) begin
                        idx_in  = '0;
                        full_in = 1'b1;
                     end else begin
                        idx_in = idx_inc[citt_pkg::RING_IDX_W-1:0];
                     end
                  end
                  citt_pkg::METHOD_BLK8: begin
                     ring_in = ring_wr;
                     if (idx_inc >= citt_pkg::BLK8_LEN) begin
                        idx_in    = '0;
                        period_in = sum8[34:3];
                     end else begin
                        idx_in = idx_inc[citt_pkg::RING_IDX_W-1:0];
                     end
                  end
                  citt_pkg::METHOD_BLK4: begin
                     ring_in = ring_wr;
                     if (idx_inc >= citt_pkg::BLK4_LEN) begin
                        idx_in    = '0;
                        period_in = sum4[33:2];
                     end else begin
                        idx_in = idx_inc[citt_pkg::RING_IDX_W-1:0];
                     end
                  end
                  citt_pkg::METHOD_MAVG2: begin
                     period_in = mavg2_sum[32:1];
                     prev_in   = capture;
                  end
                  citt_pkg::METHOD_EXP4: begin
                     period_in = {exp4_sum[33:5], 3'd0};
                  end
                  citt_pkg::METHOD_EXP8: begin
                     period_in = {exp8_sum[34:6], 3'd0};
                  end
                  citt_pkg::METHOD_DIRECT: begin
                     period_in = capture;
                  end
                  default: begin
                     period_in = period_ff;
                  end
               endcase
            end
         end
      end
   end

   assign pulse = edge_hit && changed;
   assign chg_a = pulse && !lock_a_ff;
   assign chg_b = pulse && !lock_b_ff;

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         elapsed_ff <= '0;
         period_ff  <= '0;
         for (int i = 0; i < citt_pkg::RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         idx_ff  <= '0;
         full_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         hist_ff    <= hist_in;
         elapsed_ff <= elapsed_in;
         period_ff  <= period_in;
         ring_ff    <= ring_in;
         idx_ff     <= idx_in;
         full_ff    <= full_in;
         prev_ff    <= prev_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         rsp_data_ff <= {4'd0, period_in, chg_b, chg_a, pulse, edge_hit};
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= citt_pkg::METHOD_DIRECT;
         lock_a_ff <= 1'b0;
         lock_b_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            citt_pkg::REG_METHOD: method_ff <= csr_pwdata[3:0];
            citt_pkg::REG_LOCK_A: lock_a_ff <= csr_pwdata[0];
            citt_pkg::REG_LOCK_B: lock_b_ff <= csr_pwdata[0];
            default: begin
               lock_a_ff <= lock_a_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         citt_pkg::REG_METHOD: csr_prdata = {28'd0, method_ff};
         citt_pkg::REG_LOCK_A: csr_prdata = {31'd0, lock_a_ff};
         citt_pkg::REG_LOCK_B: csr_prdata = {31'd0, lock_b_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // checks
   a_edge_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      req_accept && edge_hit |=> elapsed_ff == 32'd0)
      else $error("elapsed count not cleared after edge");

   a_tick_no_edge: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> !rsp_tdata[0])
      else $error("edge reported on tick transfer");

   a_change_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3]) |-> rsp_tdata[1] && rsp_tdata[0])
      else $error("channel flag without pulse");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(period_ff) && $stable(elapsed_ff) && $stable(idx_ff))
      else $error("state changed without transfer");

endmodule

`default_nettype wire

FILE: tb/clock_input_tempo_tracker_tb.sv
// self-checking testbench for the clock input tempo tracker
`timescale 1ns / 100ps

module clock_input_tempo_tracker_tb;

   localparam int unsigned LOW_RUN     = 12;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SEGMENTS    = 18;
   localparam int unsigned SEG_ITEMS   = 20;

   typedef struct packed {
      logic [3:0]  fill;
      logic [31:0] period_out;
      logic        changed_b;
      logic        changed_a;
      logic        clock_pulse;
      logic        edge_seen;
   } tempo_result_type;

   class tempo_tracker_check;
      logic [3:0]            method_sel;
      bit                    lock_a;
      bit                    lock_b;
      logic [LOW_RUN:0]      low_history;
      logic [31:0]           elapsed;
      logic [31:0]           period;
      logic [31:0]           ring [citt_pkg::RING_DEPTH];
      logic [citt_pkg::RING_IDX_W-1:0] ring_idx;
      bit                    ring_full;
      logic [31:0]           prev_capture;
      tempo_result_type      awaited [$];
      int unsigned           mismatches;

      function void reset_state();
         method_sel = citt_pkg::METHOD_DIRECT;
         lock_a = 0;
         lock_b = 0;
         low_history = '0;
         elapsed = '0;
         period = '0;
         foreach (ring[i]) ring[i] = '0;
         ring_idx = '0;
         ring_full = 0;
         prev_capture = '0;
         mismatches = 0;
      endfunction

      function void write_reg(citt_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            citt_pkg::REG_METHOD: method_sel = value[3:0];
            citt_pkg::REG_LOCK_A: lock_a = value[0];
            citt_pkg::REG_LOCK_B: lock_b = value[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] ring_total(int unsigned count);
         logic [63:0] sum;
         sum = '0;
         for (int unsigned i = 0; i < count; i++) sum += ring[i];
         return sum;
      endfunction

      // updates the tracked period from one capture, returns whether it counts as changed
      function bit smooth_capture(logic [31:0] c);
         logic [63:0] c64;
         logic [63:0] p64;
         logic [31:0] diff;
         logic [31:0] limit;
         int unsigned nxt;
         int unsigned len;
         c64 = {32'b0, c};
         p64 = {32'b0, period};
         if (method_sel != citt_pkg::METHOD_MAVG4 && method_sel != citt_pkg::METHOD_BLK8 &&
             method_sel != citt_pkg::METHOD_BLK4) begin
            ring_idx = '0;
            ring_full = 0;
         end
         case (method_sel)
            citt_pkg::METHOD_PCT: begin
               if (c64 * 100 > p64 * 101 || c64 * 100 < p64 * 99) begin
                  period = c;
                  return 1'b1;
               end
               return 1'b0;
            end
            citt_pkg::METHOD_FLAT5, citt_pkg::METHOD_FLAT10: begin
               diff = (c > period) ? c - period : period - c;
               limit = (method_sel == citt_pkg::METHOD_FLAT5) ? 32'd5 : 32'd10;
               if (diff > limit) begin
                  period = c;
                  return 1'b1;
               end
               return 1'b0;
            end
            citt_pkg::METHOD_MAVG4: begin
               ring[ring_idx] = c;
               period = ring_full ? 32'(ring_total(4) >> 2) : c;
               nxt = ring_idx + 1;
               if (nxt >= 4) begin
                  ring_idx = '0;
                  ring_full = 1;
               end else begin
                  ring_idx = citt_pkg::RING_IDX_W'(nxt);
               end
            end
            citt_pkg::METHOD_BLK8, citt_pkg::METHOD_BLK4: begin
               len = (method_sel == citt_pkg::METHOD_BLK8) ? 8 : 4;
               ring[ring_idx] = c;
               nxt = ring_idx + 1;
               if (nxt >= len) begin
                  ring_idx = '0;
                  period = 32'(ring_total(len) / len);
               end else begin
                  ring_idx = citt_pkg::RING_IDX_W'(nxt);
               end
            end
            citt_pkg::METHOD_MAVG2: begin
               period = 32'((c64 + {32'b0, prev_capture}) >> 1);
               prev_capture = c;
            end
            citt_pkg::METHOD_EXP4: period = 32'((c64 + p64 * 3) >> 2) & 32'hFFFF_FFF8;
            citt_pkg::METHOD_EXP8: period = 32'((c64 + p64 * 7) >> 3) & 32'hFFFF_FFF8;
            citt_pkg::METHOD_DIRECT: period = c;
            default: ;
         endcase
         return 1'b1;
      endfunction

      function void note_item(bit func, bit level);
         tempo_result_type r;
         logic [31:0]      c;
         r = '0;
         if (func) begin
            if (elapsed != 32'hFFFF_FFFF) elapsed++;
         end else begin
            low_history = {low_history[LOW_RUN-1:0], ~level};
            if (low_history == {{LOW_RUN{1'b1}}, 1'b0}) begin
               c = elapsed;
               elapsed = '0;
               r.edge_seen = 1'b1;
               if (smooth_capture(c)) begin
                  r.clock_pulse = 1'b1;
                  r.changed_a = !lock_a;
                  r.changed_b = !lock_b;
               end
            end
         end
         r.period_out = period;
         awaited.push_back(r);
      endfunction

      function void check_result(logic [39:0] data);
         tempo_result_type got;
         tempo_result_type want;
         string            bad;
         got = tempo_result_type'(data);
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h, nothing outstanding", data);
            return;
         end
         want = awaited.pop_front();
         bad = "";
         if (got.edge_seen != want.edge_seen) bad = {bad, " edge_seen"};
         if (got.clock_pulse != want.clock_pulse) bad = {bad, " clock_pulse"};
         if (got.changed_a != want.changed_a) bad = {bad, " changed_a"};
         if (got.changed_b != want.changed_b) bad = {bad, " changed_b"};
         if (got.period_out != want.period_out) bad = {bad, " period_out"};
         if (got.fill != want.fill) bad = {bad, " fill"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch in%s: expected e%0b p%0b a%0b b%0b period %0d fill %h,",
                         " got e%0b p%0b a%0b b%0b period %0d fill %h"},
                        bad, want.edge_seen, want.clock_pulse, want.changed_a, want.changed_b,
                        want.period_out, want.fill, got.edge_seen, got.clock_pulse,
                        got.changed_a, got.changed_b, got.period_out, got.fill);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // jack_level, zero fill
   logic        req_tuser = 1'b0; // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // edge_seen, clock_pulse, changed_a, changed_b,
                                 // period_out, zero fill
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tempo_tracker_check tracker;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_toggle = 0;
   bit          held_toggle = 0;
   bit          moved;

   clock_input_tempo_tracker #(.LOW_RUN(LOW_RUN)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver side, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_toggle != held_toggle) begin
         held_toggle = hold_toggle;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         moved = 0;
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_result(rsp_tdata);
            moved = 1;
         end
         if (req_tvalid && req_tready) begin
            tracker.note_item(req_tuser, req_tdata[0]);
            moved = 1;
         end
         if (csr_psel) moved = 1;
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic write_csr(citt_pkg::reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tracker.write_reg(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_item(bit func, bit level);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {7'b0, level};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // low run with ticks mixed in, closed by a high sample; a broken run has a high inside
   task automatic play_beat(int unsigned ticks, bit broken);
      int unsigned lows_left;
      int unsigned ticks_left;
      int unsigned break_at;
      lows_left = LOW_RUN;
      ticks_left = ticks;
      break_at = broken ? $urandom_range(1, LOW_RUN - 1) : 0;
      while (lows_left > 0 || ticks_left > 0) begin
         if (ticks_left > 0 && (lows_left == 0 || $urandom_range(0, 1) == 1)) begin
            send_item(1'b1, 1'($urandom_range(0, 1)));
            ticks_left--;
         end else begin
            send_item(1'b0, broken && lows_left == break_at);
            lows_left--;
         end
      end
      send_item(1'b0, 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      int unsigned base;
      int unsigned ticks;
      int unsigned pick;
      int unsigned seg_start;
      int unsigned mode;
      tracker = new;
      tracker.reset_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero period under pct: zero capture is no change, nonzero is
      write_csr(citt_pkg::REG_METHOD, {28'd0, citt_pkg::METHOD_PCT});
      write_csr(citt_pkg::REG_LOCK_A, 1);
      write_csr(citt_pkg::REG_LOCK_B, 0);
      play_beat(0, 0);
      play_beat(3, 0);

      for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
         mode = seg / 6;
         drain();
         send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 78 : 0;
         recv_stall_pct <= (mode == 0) ? 78 : (mode == 1) ? 15 : 0;
         write_csr(citt_pkg::REG_METHOD, (seg < 16) ? seg : $urandom_range(0, 15));
         write_csr(citt_pkg::REG_LOCK_A, $urandom_range(0, 1));
         write_csr(citt_pkg::REG_LOCK_B, $urandom_range(0, 1));
         if (seg == 12) hold_toggle <= ~hold_toggle;
         base = ($urandom_range(0, 4) == 0) ? $urandom_range(95, 110) : $urandom_range(0, 20);
         seg_start = items_sent;
         while (items_sent - seg_start < SEG_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) ticks = base + $urandom_range(0, 2);
            else if (pick < 96) ticks = $urandom_range(0, 40);
            else ticks = $urandom_range(100, 250);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               play_beat(ticks, 0);
            end else if (pick == 7) begin
               play_beat(ticks % 8, 1);
            end else begin
               repeat ($urandom_range(1, 5))
                  send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      end

      drain();
      repeat (3) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/citt_pkg.sv
hdl/clock_input_tempo_tracker.sv
tb/clock_input_tempo_tracker_tb.sv
